// File: rtl/btle_pkg.sv
// Shared types and constants for the BER tag and length header encoder.
// Used by btle_ctrl, btle_dp and ber_tag_length_encoder; depends on nothing.
package btle_pkg;

  localparam logic [31:0] LOW_TAG_MAX   = 32'd30;
  localparam logic [4:0]  HIGH_TAG_MARK = 5'd31;
  localparam logic [7:0]  MORE_BIT      = 8'h80;
  localparam logic [7:0]  LONG_LEN_BASE = 8'h80;

  // Which octet of the header the datapath presents.
  typedef enum logic [1:0] {
    SEL_ID   = 2'd0,
    SEL_TAG  = 2'd1,
    SEL_LENH = 2'd2,
    SEL_LENB = 2'd3
  } sel_t;

  typedef struct packed {
    logic load;
    logic tag_step;
    logic len_step;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic low_tag;
    logic short_len;
    logic tag_one;
    logic len_one;
  } stat_t;

endpackage

// File: rtl/btle_ctrl.sv
// Controller state machine that walks one header through its octets.
// Depends on btle_pkg for the command and status structs.
module btle_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last,
  input  btle_pkg::stat_t stat,
  output btle_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ID   = 5'b00010,
    S_TAG  = 5'b00100,
    S_LENH = 5'b01000,
    S_LENB = 5'b10000
  } state_t;

  state_t         state_r, state_nxt;
  logic           fire;
  logic           accept;
  btle_pkg::sel_t sel;

  assign out_valid = (state_r != S_IDLE);
  assign fire      = out_valid & out_ready;

  always_comb begin
    out_last = 1'b0;
    sel      = btle_pkg::SEL_ID;
    case (state_r)
      S_ID: begin
        sel = btle_pkg::SEL_ID;
      end
      S_TAG: begin
        sel = btle_pkg::SEL_TAG;
      end
      S_LENH: begin
        sel      = btle_pkg::SEL_LENH;
        out_last = stat.short_len;
      end
      S_LENB: begin
        sel      = btle_pkg::SEL_LENB;
        out_last = stat.len_one;
      end
      default: begin
        sel = btle_pkg::SEL_ID;
      end
    endcase
  end

  // A new request is taken in the cycle the final octet of the previous one leaves.
  assign in_ready     = (state_r == S_IDLE) | (fire & out_last);
  assign accept       = in_valid & in_ready;
  assign cmd.sel      = sel;
  assign cmd.load     = accept;
  assign cmd.tag_step = fire & (state_r == S_TAG);
  assign cmd.len_step = fire & (state_r == S_LENB);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_ID;
      end
      S_ID: begin
        if (fire) state_nxt = stat.low_tag ? S_LENH : S_TAG;
      end
      S_TAG: begin
        if (fire && stat.tag_one) state_nxt = S_LENH;
      end
      S_LENH: begin
        if (fire) begin
          if (!stat.short_len) state_nxt = S_LENB;
          else                 state_nxt = accept ? S_ID : S_IDLE;
        end
      end
      S_LENB: begin
        if (fire && stat.len_one) state_nxt = accept ? S_ID : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// File: rtl/btle_dp.sv
// Datapath: holds one header request and forms the selected output octet.
// Depends on btle_pkg for constants and the command and status structs.
module btle_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [1:0]      in_tag_class,
  input  logic            in_constructed,
  input  logic [31:0]     in_tag_number,
  input  logic [31:0]     in_content_length,
  input  btle_pkg::cmd_t  cmd,
  output btle_pkg::stat_t stat,
  output logic [7:0]      out_byte
);

  logic [2:0]  first_r;
  logic [31:0] tag_r;
  logic [31:0] len_r;
  logic [2:0]  tgcnt_r, tgcnt_nxt;
  logic [2:0]  lncnt_r, lncnt_nxt;
  logic [6:0]  grp;
  logic [7:0]  lbyte;
  logic [7:0]  id_byte;

  // Counts of base-128 tag groups and of long-form length octets.
  always_comb begin
    if (in_tag_number[31:28] != 4'd0)      tgcnt_nxt = 3'd5;
    else if (in_tag_number[27:21] != 7'd0) tgcnt_nxt = 3'd4;
    else if (in_tag_number[20:14] != 7'd0) tgcnt_nxt = 3'd3;
    else if (in_tag_number[13:7] != 7'd0)  tgcnt_nxt = 3'd2;
    else                                   tgcnt_nxt = 3'd1;
    if (in_content_length[31:24] != 8'd0)      lncnt_nxt = 3'd4;
    else if (in_content_length[23:16] != 8'd0) lncnt_nxt = 3'd3;
    else if (in_content_length[15:8] != 8'd0)  lncnt_nxt = 3'd2;
    else                                       lncnt_nxt = 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgcnt_r <= 3'd1;
      lncnt_r <= 3'd1;
    end else if (cmd.load) begin
      tgcnt_r <= tgcnt_nxt;
      lncnt_r <= lncnt_nxt;
    end else begin
      if (cmd.tag_step) tgcnt_r <= tgcnt_r - 3'd1;
      if (cmd.len_step) lncnt_r <= lncnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r <= {in_tag_class, in_constructed};
      tag_r   <= in_tag_number;
      len_r   <= in_content_length;
    end
  end

  assign stat.low_tag   = (tag_r <= btle_pkg::LOW_TAG_MAX);
  assign stat.short_len = (len_r[31:7] == 25'd0);
  assign stat.tag_one   = (tgcnt_r == 3'd1);
  assign stat.len_one   = (lncnt_r == 3'd1);

  always_comb begin
    case (tgcnt_r)
      3'd5:    grp = {3'b000, tag_r[31:28]};
      3'd4:    grp = tag_r[27:21];
      3'd3:    grp = tag_r[20:14];
      3'd2:    grp = tag_r[13:7];
      default: grp = tag_r[6:0];
    endcase
    case (lncnt_r)
      3'd4:    lbyte = len_r[31:24];
      3'd3:    lbyte = len_r[23:16];
      3'd2:    lbyte = len_r[15:8];
      default: lbyte = len_r[7:0];
    endcase
  end

  assign id_byte = {first_r,
                    stat.low_tag ? tag_r[4:0] : btle_pkg::HIGH_TAG_MARK};

  always_comb begin
    case (cmd.sel)
      btle_pkg::SEL_ID: begin
        out_byte = id_byte;
      end
      btle_pkg::SEL_TAG: begin
        out_byte = (stat.tag_one ? 8'h00 : btle_pkg::MORE_BIT) | {1'b0, grp};
      end
      btle_pkg::SEL_LENH: begin
        out_byte = stat.short_len ? {1'b0, len_r[6:0]}
                                  : (btle_pkg::LONG_LEN_BASE | {5'd0, lncnt_r});
      end
      btle_pkg::SEL_LENB: begin
        out_byte = lbyte;
      end
      default: begin
        out_byte = id_byte;
      end
    endcase
  end

endmodule

// File: rtl/ber_tag_length_encoder.sv
// Top level of the BER identifier and length header encoder.
// Joins btle_ctrl and btle_dp; depends on btle_pkg.
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    tag_class, constructed, tag_number,
//                                             content_length
//  out      output     out_valid / out_ready  out_byte, out_last (one octet a word)
//
// One request yields 2 to 11 octets, one word per cycle while out_ready is high;
// the controller's octet walk sets how many octets a request yields.
// The next request is taken in the cycle its predecessor's last octet leaves.
// Reset (rst_n low, synchronous) returns the controller to idle.
// While out_ready is low the current octet and all counters hold.
module ber_tag_length_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_tag_class,
  input  logic        in_constructed,
  input  logic [31:0] in_tag_number,
  input  logic [31:0] in_content_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  btle_pkg::cmd_t  cmd;
  btle_pkg::stat_t stat;

  btle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  btle_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tag_class      (in_tag_class),
    .in_constructed    (in_constructed),
    .in_tag_number     (in_tag_number),
    .in_content_length (in_content_length),
    .cmd               (cmd),
    .stat              (stat),
    .out_byte          (out_byte)
  );

endmodule
